// File: rtl/core/flat_file_directory_engine_macros.svh
// Assertion macros for the flat file directory engine.
// Depends on nothing; included by the RTL files that carry assertions.
`ifndef FLAT_FILE_DIRECTORY_ENGINE_MACROS_SVH
`define FLAT_FILE_DIRECTORY_ENGINE_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define FFDE_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define FFDE_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFDE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/ffde_pkg.sv
// Shared types and codes of the flat file directory engine.
// No dependencies; imported by ffde_slot_check and flat_file_directory_engine.
`timescale 1ns / 1ps

package ffde_pkg;

   localparam int NAME_W     = 64;
   localparam int WORD_W     = 16;
   localparam int LEN_W      = 21;
   localparam int CMD_W      = 3;
   localparam int STAT_W     = 3;
   localparam int SLOT_OUT_W = 7;
   localparam int FILES_W    = 8;

   localparam logic [CMD_W-1:0] CMD_FIND_NAME = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FIND_BOOT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FORMAT    = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd1;
   localparam logic [STAT_W-1:0] STAT_BAD_NAME  = 3'd2;
   localparam logic [STAT_W-1:0] STAT_DIR_FULL  = 3'd3;
   localparam logic [STAT_W-1:0] STAT_DISK_FULL = 3'd4;

   typedef struct packed {
      logic [NAME_W-1:0] name;
      logic [WORD_W-1:0] ftype;
      logic [WORD_W-1:0] flags;
      logic [LEN_W-1:0]  offset;
      logic [LEN_W-1:0]  length;
   } entry_type;

   typedef struct packed {
      logic is_free;
      logic name_hit;
      logic boot_hit;
   } slot_check_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_FINISH
   } state_type;

endpackage

// File: rtl/core/ffde_slot_check.sv
// Shared slot compare unit: checks one directory entry against the search key.
// Depends on ffde_pkg.
`timescale 1ns / 1ps

module ffde_slot_check (
   input  ffde_pkg::entry_type            entry,
   input  logic [ffde_pkg::NAME_W-1:0]    key_name,
   input  logic [ffde_pkg::WORD_W-1:0]    boot_mask,
   output ffde_pkg::slot_check_type       check
);
   import ffde_pkg::*;

   logic slot_free;

   assign slot_free = (entry.name == '0);

   always_comb begin
      check          = '0;
      check.is_free  = slot_free;
      // an empty key never matches, so free slots are never name hits
      check.name_hit = (key_name != '0) && (entry.name == key_name);
      check.boot_hit = !slot_free && ((entry.flags & boot_mask) != '0);
   end

endmodule

// File: rtl/core/flat_file_directory_engine.sv
// Flat file directory engine: top level with sequencer, directory memory and result register.
// Depends on ffde_pkg, ffde_slot_check and flat_file_directory_engine_macros.svh.
`timescale 1ns / 1ps
//
// Usage
//   Request channel (req_valid/req_ready) carries one command item: find by
//   name, find first bootable, write, delete or format. Each item produces
//   exactly one result item on the response channel (rsp_valid/rsp_ready).
//   csr_write_enable/csr_write_data load the bootable mask at once; write it
//   only while the engine is idle.
// Timing
//   Find, write and delete scan the directory one slot per cycle through a
//   single read port and one shared compare unit; a hit stops the scan early.
//   An empty name for find by name, write or delete, or an unknown command,
//   skips the scan. Format sweeps every slot to zero, one per cycle.
//   req_ready is high only while the sequencer waits for a command.
// Reset
//   After reset the engine runs a clearing pass over the directory memory
//   and accepts no item meanwhile.
// Back pressure
//   The result sits in an output register; the engine takes the next item
//   while it waits. A second result waits in the sequencer until the first
//   is taken.

`include "flat_file_directory_engine_macros.svh"

module flat_file_directory_engine #(
   parameter int MAX_ENTRIES     = 128,
   parameter int DISK_SIZE_WORDS = 1048576,
   parameter int DATA_START      = 2053
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_write_enable,
   input  logic [ffde_pkg::WORD_W-1:0]       csr_write_data,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ffde_pkg::CMD_W-1:0]        req_command,
   input  logic [ffde_pkg::NAME_W-1:0]       req_file_name,
   input  logic [ffde_pkg::WORD_W-1:0]       req_file_type,
   input  logic [ffde_pkg::WORD_W-1:0]       req_file_flags,
   input  logic [ffde_pkg::LEN_W-1:0]        req_word_count,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ffde_pkg::STAT_W-1:0]       rsp_status,
   output logic [ffde_pkg::SLOT_OUT_W-1:0]   rsp_slot_index,
   output logic [ffde_pkg::NAME_W-1:0]       rsp_found_name,
   output logic [ffde_pkg::WORD_W-1:0]       rsp_found_type,
   output logic [ffde_pkg::WORD_W-1:0]       rsp_found_flags,
   output logic [ffde_pkg::LEN_W-1:0]        rsp_data_offset,
   output logic [ffde_pkg::LEN_W-1:0]        rsp_data_length,
   output logic [ffde_pkg::FILES_W-1:0]      rsp_files_present
);
   import ffde_pkg::*;

   localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int DISK_W = $clog2(DISK_SIZE_WORDS + 1);
   localparam int SUM_W  = (DISK_W > LEN_W + 1) ? DISK_W : LEN_W + 1;

   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(MAX_ENTRIES - 1);
   localparam logic [CNT_W-1:0] TOTAL_MAX  = CNT_W'(MAX_ENTRIES);
   localparam logic [LEN_W-1:0] FP_RESET   = LEN_W'(DATA_START);
   localparam logic [SUM_W-1:0] DISK_LIMIT = SUM_W'(DISK_SIZE_WORDS);

   // drop every byte from the first zero byte on
   function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] res;
      logic              ended;
      res   = '0;
      ended = 1'b0;
      for (int i = 0; i < NAME_W / 8; i++) begin
         if (raw[8*i +: 8] == 8'h00) ended = 1'b1;
         if (!ended) res[8*i +: 8] = raw[8*i +: 8];
      end
      return res;
   endfunction

   // directory memory: one write port, one registered read port
   entry_type dir_mem [MAX_ENTRIES];
   entry_type rd_data_ff;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   entry_type            mem_wdata;

   // sequencer state
   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     clr_idx_ff, clr_idx_in;
   logic [IDX_W-1:0]     scan_idx_ff, scan_idx_in;
   logic                 iss_done_ff, iss_done_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 hit_ff, hit_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   entry_type            hit_entry_ff, hit_entry_in;
   logic                 free_ff, free_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;

   // latched command
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [NAME_W-1:0]    key_ff, key_in;
   logic [WORD_W-1:0]    type_ff, type_in;
   logic [WORD_W-1:0]    flags_ff, flags_in;
   logic [LEN_W-1:0]     count_ff, count_in;

   // architectural state
   logic [WORD_W-1:0]    mask_ff, mask_in;
   logic [CNT_W-1:0]     file_total_ff, file_total_in;
   logic [LEN_W-1:0]     free_ptr_ff, free_ptr_in;

   // staged result
   logic [STAT_W-1:0]    res_status_ff, res_status_in;
   logic [IDX_W-1:0]     res_slot_ff, res_slot_in;
   entry_type            res_entry_ff, res_entry_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_load;
   logic [STAT_W-1:0]    rsp_status_ff;
   logic [IDX_W-1:0]     rsp_slot_ff;
   entry_type            rsp_entry_ff;
   logic [CNT_W-1:0]     rsp_total_ff;

   logic [NAME_W-1:0]    req_key;
   slot_check_type       chk;
   logic                 slot_hit;
   logic [SUM_W-1:0]     fp_sum;
   logic [IDX_W-1:0]     wr_slot;
   entry_type            new_entry;

   assign req_key = canon_name(req_file_name);

   ffde_slot_check u_slot_check (
      .entry     (rd_data_ff),
      .key_name  (key_ff),
      .boot_mask (mask_ff),
      .check     (chk)
   );

   assign slot_hit  = (cmd_ff == CMD_FIND_BOOT) ? chk.boot_hit : chk.name_hit;
   assign fp_sum    = SUM_W'(free_ptr_ff) + SUM_W'(count_ff);
   assign wr_slot   = hit_ff ? hit_idx_ff : free_idx_ff;

   always_comb begin
      new_entry        = '0;
      new_entry.name   = key_ff;
      new_entry.ftype  = type_ff;
      new_entry.flags  = flags_ff;
      new_entry.offset = free_ptr_ff;
      new_entry.length = count_ff;
   end

   // memory: write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         dir_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= dir_mem[scan_idx_ff];
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_idx_ff    <= '0;
         iss_done_ff   <= 1'b1;
         rd_vld_ff     <= 1'b0;
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
         cmd_ff        <= CMD_FIND_NAME;
         mask_ff       <= 16'h0001;
         file_total_ff <= '0;
         free_ptr_ff   <= FP_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         iss_done_ff   <= iss_done_in;
         rd_vld_ff     <= rd_vld_in;
         hit_ff        <= hit_in;
         free_ff       <= free_in;
         cmd_ff        <= cmd_in;
         mask_ff       <= mask_in;
         file_total_ff <= file_total_in;
         free_ptr_ff   <= free_ptr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      rd_idx_ff     <= rd_idx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_entry_ff  <= hit_entry_in;
      free_idx_ff   <= free_idx_in;
      key_ff        <= key_in;
      type_ff       <= type_in;
      flags_ff      <= flags_in;
      count_ff      <= count_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_entry_ff  <= res_entry_in;
      if (out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_entry_ff  <= res_entry_ff;
         rsp_total_ff  <= file_total_ff;
      end
   end

   // sequencer: next state and datapath control
   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      scan_idx_in   = scan_idx_ff;
      iss_done_in   = iss_done_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_entry_in  = hit_entry_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      type_in       = type_ff;
      flags_in      = flags_ff;
      count_in      = count_ff;
      mask_in       = csr_write_enable ? csr_write_data : mask_ff;
      file_total_in = file_total_ff;
      free_ptr_in   = free_ptr_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_entry_in  = res_entry_ff;
      mem_we        = 1'b0;
      mem_waddr     = clr_idx_ff;
      mem_wdata     = '0;
      req_ready     = 1'b0;
      out_load      = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            // zero one slot per cycle
            mem_we    = 1'b1;
            mem_waddr = clr_idx_ff;
            if (clr_idx_ff == LAST_IDX) begin
               clr_idx_in = '0;
               if (cmd_ff == CMD_FORMAT) begin
                  res_status_in = STAT_OK;
                  state_in      = ST_FINISH;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               clr_idx_in = clr_idx_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in        = req_command;
               key_in        = req_key;
               type_in       = req_file_type;
               flags_in      = req_file_flags;
               count_in      = req_word_count;
               scan_idx_in   = '0;
               iss_done_in   = 1'b0;
               hit_in        = 1'b0;
               free_in       = 1'b0;
               res_status_in = STAT_NOT_FOUND;
               res_slot_in   = '0;
               res_entry_in  = '0;
               case (req_command)
                  CMD_FIND_NAME, CMD_DELETE: begin
                     state_in = (req_key == '0) ? ST_FINISH : ST_SCAN;
                  end
                  CMD_FIND_BOOT: begin
                     state_in = ST_SCAN;
                  end
                  CMD_WRITE: begin
                     if (req_key == '0) begin
                        res_status_in = STAT_BAD_NAME;
                        state_in      = ST_FINISH;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_FORMAT: begin
                     file_total_in = '0;
                     free_ptr_in   = FP_RESET;
                     clr_idx_in    = '0;
                     state_in      = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // issue the next read while checking the slot read last cycle
            if (!iss_done_ff) begin
               rd_vld_in   = 1'b1;
               rd_idx_in   = scan_idx_ff;
               scan_idx_in = scan_idx_ff + 1'b1;
               if (scan_idx_ff == LAST_IDX) begin
                  iss_done_in = 1'b1;
               end
            end
            if (rd_vld_ff) begin
               if (cmd_ff == CMD_WRITE && chk.is_free && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if (slot_hit) begin
                  hit_in       = 1'b1;
                  hit_idx_in   = rd_idx_ff;
                  hit_entry_in = rd_data_ff;
                  state_in     = ST_DECIDE;
               end else if (rd_idx_ff == LAST_IDX) begin
                  state_in = ST_DECIDE;
               end
            end
         end

         ST_DECIDE: begin
            state_in = ST_FINISH;
            case (cmd_ff)
               CMD_FIND_NAME, CMD_FIND_BOOT: begin
                  if (hit_ff) begin
                     res_status_in = STAT_OK;
                     res_slot_in   = hit_idx_ff;
                     res_entry_in  = hit_entry_ff;
                  end
               end
               CMD_DELETE: begin
                  if (hit_ff) begin
                     // report the entry as it was, then clear the slot
                     res_status_in = STAT_OK;
                     res_slot_in   = hit_idx_ff;
                     res_entry_in  = hit_entry_ff;
                     mem_we        = 1'b1;
                     mem_waddr     = hit_idx_ff;
                     mem_wdata     = '0;
                     if (file_total_ff != '0) begin
                        file_total_in = file_total_ff - 1'b1;
                     end
                  end
               end
               CMD_WRITE: begin
                  if (!hit_ff && !free_ff) begin
                     res_status_in = STAT_DIR_FULL;
                  end else if (fp_sum > DISK_LIMIT) begin
                     res_status_in = STAT_DISK_FULL;
                  end else begin
                     res_status_in = STAT_OK;
                     res_slot_in   = wr_slot;
                     res_entry_in  = new_entry;
                     mem_we        = 1'b1;
                     mem_waddr     = wr_slot;
                     mem_wdata     = new_entry;
                     free_ptr_in   = fp_sum[LEN_W-1:0];
                     if (!hit_ff) begin
                        file_total_in = file_total_ff + 1'b1;
                     end
                  end
               end
               default: begin
                  res_status_in = STAT_NOT_FOUND;
               end
            endcase
         end

         ST_FINISH: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: load wins over a drain in the same cycle
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot_index    = SLOT_OUT_W'(rsp_slot_ff);
   assign rsp_found_name    = rsp_entry_ff.name;
   assign rsp_found_type    = rsp_entry_ff.ftype;
   assign rsp_found_flags   = rsp_entry_ff.flags;
   assign rsp_data_offset   = rsp_entry_ff.offset;
   assign rsp_data_length   = rsp_entry_ff.length;
   assign rsp_files_present = FILES_W'(rsp_total_ff);

   `FFDE_ASSERT_ALWAYS(a_total_cap, clock, reset, file_total_ff <= TOTAL_MAX, "count over cap")
   `FFDE_ASSERT_IMPLY(a_err_zero, clock, reset, rsp_valid && rsp_status != STAT_OK, rsp_found_name == '0, "err name")
   `FFDE_ASSERT_NEXT(a_busy_after, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")
   `FFDE_ASSERT_IMPLY(a_wr_state, clock, reset, mem_we, state_ff == ST_CLEAR || state_ff == ST_DECIDE, "stray write")

endmodule
